[sv/dep_pkg.sv]
// Shared types and constants of the delayed event pool.
// Used by the controller, the datapath and the top level; depends on nothing.
package dep_pkg;

  localparam int TGT_W       = 16;
  localparam int EVT_W       = 16;
  localparam int DLY_W       = 32;
  localparam int PRIO_W      = 8;
  localparam int ARGC_IN_W   = 8;
  localparam int ARGC_W      = 3;
  localparam int ARG_W       = 32;
  localparam int ELAP_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int ACTIVE_W    = 7;
  localparam int OUT_ARGS    = 4;
  localparam int IN_TDATA_W  = 224;
  localparam int OUT_TDATA_W = 176;

  localparam logic KIND_POST = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register index as decoded from paddr[2].
  localparam logic REG_EMPTY_HANDLE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_POSTED    = 3'd0,
    ST_EVICTED   = 3'd1,
    ST_REJ_EMPTY = 3'd2,
    ST_REJ_FULL  = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE      = 3'd5
  } dep_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_FINISH
  } dep_state_e;

  typedef struct packed {
    logic capture;
    logic start;
    logic step;
    logic finish;
  } dep_cmd_t;

  typedef struct packed {
    logic fire_wait;
    logic last_idx;
    logic out_free;
  } dep_sts_t;

endpackage

[sv/delayed_event_pool.sv]
// A pool of SLOTS timed event slots. Each transaction (post or tick) holds the block
// from the accepting cycle through a start state that starts the slot memory read,
// a scan state that sweeps the single-read-port slot memory in index order, stalling
// while a fired event waits on a stalled result output, and a finish state that loads
// the final result into the output register once the output is free; the next
// transaction is accepted only back in idle. empty_handle sits at byte address 0.
// Depends on dep_pkg, dep_ctrl, dep_dp and dep_ram.
module delayed_event_pool #(
  parameter int SLOTS = 64,
  parameter int ARGS  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // target, event identifier, delay, priority, argument count, arg0..arg3, elapsed
  input  logic [dep_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // kind
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // fired_target, fired_event_id, fired_arg_count, out_arg0..out_arg3,
  // active_count, zero fill
  output logic [dep_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status
  output logic [dep_pkg::STATUS_W-1:0]      m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [dep_pkg::TGT_W-1:0] empty_handle_q;
  dep_pkg::dep_cmd_t cmd;
  dep_pkg::dep_sts_t sts;

  logic [dep_pkg::OUT_ARGS-1:0][dep_pkg::ARG_W-1:0] in_args;
  logic [dep_pkg::OUT_ARGS-1:0][dep_pkg::ARG_W-1:0] out_args;
  logic [dep_pkg::TGT_W-1:0]    out_tgt;
  logic [dep_pkg::EVT_W-1:0]    out_evt;
  logic [dep_pkg::ARGC_W-1:0]   out_argc;
  logic [dep_pkg::ACTIVE_W-1:0] out_act;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dep_pkg::REG_EMPTY_HANDLE)
                ? {{(32 - dep_pkg::TGT_W){1'b0}}, empty_handle_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_handle_q <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == dep_pkg::REG_EMPTY_HANDLE)) begin
      empty_handle_q <= pwdata[dep_pkg::TGT_W-1:0];
    end
  end

  assign in_args = s_axis_tdata_i[207:80];

  dep_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dep_dp #(
    .SLOTS (SLOTS),
    .ARGS  (ARGS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .empty_handle_i (empty_handle_q),
    .in_kind_i      (s_axis_tuser_i),
    .in_target_i    (s_axis_tdata_i[15:0]),
    .in_event_i     (s_axis_tdata_i[31:16]),
    .in_delay_i     (s_axis_tdata_i[63:32]),
    .in_prio_i      (s_axis_tdata_i[71:64]),
    .in_argc_i      (s_axis_tdata_i[79:72]),
    .in_args_i      (in_args),
    .in_elapsed_i   (s_axis_tdata_i[223:208]),
    .m_ready_i      (m_axis_tready_i),
    .m_valid_o      (m_axis_tvalid_o),
    .m_status_o     (m_axis_tuser_o),
    .m_target_o     (out_tgt),
    .m_event_o      (out_evt),
    .m_argc_o       (out_argc),
    .m_args_o       (out_args),
    .m_active_o     (out_act),
    .m_last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b0, out_act, out_args, out_argc, out_evt, out_tgt};

endmodule

[sv/dep_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the slot entries of the event pool; no dependencies.
module dep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dep_ctrl.sv]
// Sequencing controller of the delayed event pool.
// Depends on dep_pkg; drives the datapath through command and status structs.
module dep_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  dep_pkg::dep_sts_t sts_i,
  output dep_pkg::dep_cmd_t cmd_o
);

  dep_pkg::dep_state_e state_q, state_d;
  logic advance;

  assign advance = !(sts_i.fire_wait && !sts_i.out_free);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dep_pkg::S_IDLE: begin
        if (s_valid_i) state_d = dep_pkg::S_START;
      end
      dep_pkg::S_START: state_d = dep_pkg::S_SCAN;
      dep_pkg::S_SCAN: begin
        if (advance && sts_i.last_idx) state_d = dep_pkg::S_FINISH;
      end
      dep_pkg::S_FINISH: begin
        if (sts_i.out_free) state_d = dep_pkg::S_IDLE;
      end
      default: state_d = dep_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      dep_pkg::S_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      dep_pkg::S_START:  cmd_o.start  = 1'b1;
      dep_pkg::S_SCAN:   cmd_o.step   = advance;
      dep_pkg::S_FINISH: cmd_o.finish = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dep_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_capture_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == dep_pkg::S_START)
    else $error("accepted transaction did not start a scan");

  a_finish_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == dep_pkg::S_IDLE)
    else $error("finished transaction did not return to idle");

endmodule

[sv/dep_dp.sv]
// Datapath of the delayed event pool: item registers, slot memory, valid bits,
// scan state, pending fired event and output register. Uses dep_pkg and dep_ram.
module dep_dp #(
  parameter int SLOTS = 64,
  parameter int ARGS  = 4
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  dep_pkg::dep_cmd_t                           cmd_i,
  output dep_pkg::dep_sts_t                           sts_o,
  input  logic [dep_pkg::TGT_W-1:0]                   empty_handle_i,
  input  logic                                        in_kind_i,
  input  logic [dep_pkg::TGT_W-1:0]                   in_target_i,
  input  logic [dep_pkg::EVT_W-1:0]                   in_event_i,
  input  logic [dep_pkg::DLY_W-1:0]                   in_delay_i,
  input  logic [dep_pkg::PRIO_W-1:0]                  in_prio_i,
  input  logic [dep_pkg::ARGC_IN_W-1:0]               in_argc_i,
  input  logic [dep_pkg::OUT_ARGS-1:0][dep_pkg::ARG_W-1:0] in_args_i,
  input  logic [dep_pkg::ELAP_W-1:0]                  in_elapsed_i,
  input  logic                                        m_ready_i,
  output logic                                        m_valid_o,
  output logic [dep_pkg::STATUS_W-1:0]                m_status_o,
  output logic [dep_pkg::TGT_W-1:0]                   m_target_o,
  output logic [dep_pkg::EVT_W-1:0]                   m_event_o,
  output logic [dep_pkg::ARGC_W-1:0]                  m_argc_o,
  output logic [dep_pkg::OUT_ARGS-1:0][dep_pkg::ARG_W-1:0] m_args_o,
  output logic [dep_pkg::ACTIVE_W-1:0]                m_active_o,
  output logic                                        m_last_o
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int O_EVT  = dep_pkg::TGT_W;
  localparam int O_DLY  = O_EVT + dep_pkg::EVT_W;
  localparam int O_PRIO = O_DLY + dep_pkg::DLY_W;
  localparam int O_ARGC = O_PRIO + dep_pkg::PRIO_W;
  localparam int O_ARGS = O_ARGC + dep_pkg::ARGC_W;
  localparam int ENT_W  = O_ARGS + ARGS * dep_pkg::ARG_W;

  // Item registers.
  logic                                    kind_q;
  logic [dep_pkg::TGT_W-1:0]               tgt_q;
  logic [dep_pkg::EVT_W-1:0]               evt_q;
  logic [dep_pkg::DLY_W-1:0]               dly_q;
  logic [dep_pkg::PRIO_W-1:0]              prio_q;
  logic [dep_pkg::ARGC_W-1:0]              argc_q;
  logic [ARGS-1:0][dep_pkg::ARG_W-1:0]     args_q;
  logic [dep_pkg::ELAP_W-1:0]              ms_q;

  logic [dep_pkg::ARGC_W-1:0]              argc_cl;

  // Scan and pool state.
  logic [SLOTS-1:0]                        valid_q;
  logic [CNT_W-1:0]                        count_q;
  logic [IDX_W-1:0]                        idx_q;
  logic                                    free_found_q;
  logic [IDX_W-1:0]                        free_idx_q;
  logic                                    vfound_q;
  logic [IDX_W-1:0]                        vidx_q;
  logic [dep_pkg::PRIO_W-1:0]              vprio_q;
  logic signed [dep_pkg::DLY_W-1:0]        vdly_q;

  // Pending fired event, held until it is known whether it is the last one.
  logic                                    pend_v_q;
  logic [dep_pkg::TGT_W-1:0]               pend_tgt_q;
  logic [dep_pkg::EVT_W-1:0]               pend_evt_q;
  logic [dep_pkg::ARGC_W-1:0]              pend_argc_q;
  logic [ARGS-1:0][dep_pkg::ARG_W-1:0]     pend_args_q;
  logic [CNT_W-1:0]                        pend_act_q;

  // Output register.
  logic                                    m_valid_q;
  logic [dep_pkg::STATUS_W-1:0]            m_status_q;
  logic [dep_pkg::TGT_W-1:0]               m_tgt_q;
  logic [dep_pkg::EVT_W-1:0]               m_evt_q;
  logic [dep_pkg::ARGC_W-1:0]              m_argc_q;
  logic [dep_pkg::OUT_ARGS-1:0][dep_pkg::ARG_W-1:0] m_args_q;
  logic [dep_pkg::ACTIVE_W-1:0]            m_act_q;
  logic                                    m_last_q;

  // Memory interface.
  logic                                    we;
  logic [IDX_W-1:0]                        waddr;
  logic [ENT_W-1:0]                        wdata;
  logic [IDX_W-1:0]                        raddr;
  logic [ENT_W-1:0]                        rdata;

  logic [dep_pkg::TGT_W-1:0]               r_tgt;
  logic [dep_pkg::EVT_W-1:0]               r_evt;
  logic signed [dep_pkg::DLY_W-1:0]        r_dly;
  logic [dep_pkg::PRIO_W-1:0]              r_prio;
  logic [dep_pkg::ARGC_W-1:0]              r_argc;
  logic [ARGS-1:0][dep_pkg::ARG_W-1:0]     r_args;

  logic                                    cur_v;
  logic signed [dep_pkg::DLY_W:0]          diff;
  logic [dep_pkg::DLY_W-1:0]               new_dly;
  logic                                    fire;
  logic                                    tick_fire;
  logic                                    better;
  logic                                    empty_tgt;
  logic                                    can_evict;
  logic                                    post_wr;
  logic [ENT_W-1:0]                        new_ent;
  logic [ENT_W-1:0]                        upd_ent;

  logic                                    out_free;
  logic                                    out_load;
  logic [dep_pkg::STATUS_W-1:0]            o_status;
  logic [dep_pkg::TGT_W-1:0]               o_tgt;
  logic [dep_pkg::EVT_W-1:0]               o_evt;
  logic [dep_pkg::ARGC_W-1:0]              o_argc;
  logic [dep_pkg::OUT_ARGS-1:0][dep_pkg::ARG_W-1:0] o_args;
  logic [dep_pkg::ACTIVE_W-1:0]            o_act;
  logic                                    o_last;

  assign argc_cl = (in_argc_i > dep_pkg::ARGC_IN_W'(ARGS)) ? dep_pkg::ARGC_W'(ARGS)
                                                            : in_argc_i[dep_pkg::ARGC_W-1:0];

  dep_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign r_tgt  = rdata[O_EVT-1:0];
  assign r_evt  = rdata[O_DLY-1:O_EVT];
  assign r_dly  = $signed(rdata[O_PRIO-1:O_DLY]);
  assign r_prio = rdata[O_ARGC-1:O_PRIO];
  assign r_argc = rdata[O_ARGS-1:O_ARGC];
  assign r_args = rdata[ENT_W-1:O_ARGS];

  assign cur_v   = valid_q[idx_q];
  assign diff    = {r_dly[dep_pkg::DLY_W-1], r_dly}
                 - $signed({{(dep_pkg::DLY_W + 1 - dep_pkg::ELAP_W){1'b0}}, ms_q});
  assign new_dly = (diff[dep_pkg::DLY_W] != diff[dep_pkg::DLY_W-1])
                 ? {1'b1, {(dep_pkg::DLY_W - 1){1'b0}}} : diff[dep_pkg::DLY_W-1:0];
  assign fire    = new_dly[dep_pkg::DLY_W-1] || (new_dly == '0);

  assign tick_fire = cmd_i.step && (kind_q == dep_pkg::KIND_TICK) && cur_v && fire;

  assign better = !vfound_q || (r_prio < vprio_q)
               || ((r_prio == vprio_q) && (r_dly > vdly_q));

  assign empty_tgt = (tgt_q == empty_handle_i);
  assign can_evict = vfound_q && (vprio_q < prio_q);
  assign post_wr   = (kind_q == dep_pkg::KIND_POST) && !empty_tgt
                  && (free_found_q || can_evict);

  assign new_ent = {args_q, argc_q, prio_q, dly_q, evt_q, tgt_q};
  assign upd_ent = {rdata[ENT_W-1:O_PRIO], new_dly, rdata[O_DLY-1:0]};

  always_comb begin
    raddr = idx_q;
    if (cmd_i.start) begin
      raddr = '0;
    end else if (cmd_i.step) begin
      raddr = IDX_W'(idx_q + 1'b1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = upd_ent;
    if (cmd_i.step && (kind_q == dep_pkg::KIND_TICK) && cur_v) begin
      we = 1'b1;
    end else if (cmd_i.finish && post_wr) begin
      we    = 1'b1;
      waddr = free_found_q ? free_idx_q : vidx_q;
      wdata = new_ent;
    end
  end

  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    out_load = 1'b0;
    o_status = dep_pkg::ST_NONE;
    o_tgt    = '0;
    o_evt    = '0;
    o_argc   = '0;
    o_args   = '0;
    o_act    = dep_pkg::ACTIVE_W'(count_q);
    o_last   = 1'b1;
    if (tick_fire && pend_v_q) begin
      out_load = 1'b1;
      o_status = dep_pkg::ST_FIRED;
      o_tgt    = pend_tgt_q;
      o_evt    = pend_evt_q;
      o_argc   = pend_argc_q;
      for (int j = 0; j < ARGS; j++) o_args[j] = pend_args_q[j];
      o_act    = dep_pkg::ACTIVE_W'(pend_act_q);
      o_last   = 1'b0;
    end else if (cmd_i.finish) begin
      out_load = 1'b1;
      if (kind_q == dep_pkg::KIND_TICK) begin
        if (pend_v_q) begin
          o_status = dep_pkg::ST_FIRED;
          o_tgt    = pend_tgt_q;
          o_evt    = pend_evt_q;
          o_argc   = pend_argc_q;
          for (int j = 0; j < ARGS; j++) o_args[j] = pend_args_q[j];
          o_act    = dep_pkg::ACTIVE_W'(pend_act_q);
        end
      end else if (empty_tgt) begin
        o_status = dep_pkg::ST_REJ_EMPTY;
      end else if (free_found_q) begin
        o_status = dep_pkg::ST_POSTED;
        o_act    = dep_pkg::ACTIVE_W'(count_q + 1'b1);
      end else if (can_evict) begin
        o_status = dep_pkg::ST_EVICTED;
      end else begin
        o_status = dep_pkg::ST_REJ_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      vfound_q     <= 1'b0;
      pend_v_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        idx_q        <= '0;
        free_found_q <= 1'b0;
        vfound_q     <= 1'b0;
        pend_v_q     <= 1'b0;
      end else if (cmd_i.step) begin
        idx_q <= IDX_W'(idx_q + 1'b1);
        if (kind_q == dep_pkg::KIND_POST) begin
          if (!cur_v && !free_found_q) free_found_q <= 1'b1;
          if (cur_v && better) vfound_q <= 1'b1;
        end else if (tick_fire) begin
          valid_q[idx_q] <= 1'b0;
          count_q        <= count_q - 1'b1;
          pend_v_q       <= 1'b1;
        end
      end else if (cmd_i.finish && post_wr && free_found_q) begin
        valid_q[free_idx_q] <= 1'b1;
        count_q             <= count_q + 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      tgt_q  <= in_target_i;
      evt_q  <= in_event_i;
      dly_q  <= in_delay_i;
      prio_q <= in_prio_i;
      argc_q <= argc_cl;
      for (int j = 0; j < ARGS; j++) begin
        args_q[j] <= (dep_pkg::ARGC_W'(j) < argc_cl) ? in_args_i[j] : '0;
      end
      ms_q <= (in_elapsed_i == '0) ? dep_pkg::ELAP_W'(1) : in_elapsed_i;
    end
    if (cmd_i.step && (kind_q == dep_pkg::KIND_POST)) begin
      if (!cur_v && !free_found_q) free_idx_q <= idx_q;
      if (cur_v && better) begin
        vidx_q  <= idx_q;
        vprio_q <= r_prio;
        vdly_q  <= r_dly;
      end
    end
    if (tick_fire) begin
      pend_tgt_q  <= r_tgt;
      pend_evt_q  <= r_evt;
      pend_argc_q <= r_argc;
      pend_args_q <= r_args;
      pend_act_q  <= count_q - 1'b1;
    end
    if (out_load) begin
      m_status_q <= o_status;
      m_tgt_q    <= o_tgt;
      m_evt_q    <= o_evt;
      m_argc_q   <= o_argc;
      m_args_q   <= o_args;
      m_act_q    <= o_act;
      m_last_q   <= o_last;
    end
  end

  assign sts_o.fire_wait = (kind_q == dep_pkg::KIND_TICK) && cur_v && fire && pend_v_q;
  assign sts_o.last_idx  = (idx_q == IDX_W'(SLOTS - 1));
  assign sts_o.out_free  = out_free;

  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_target_o = m_tgt_q;
  assign m_event_o  = m_evt_q;
  assign m_argc_o   = m_argc_q;
  assign m_args_o   = m_args_q;
  assign m_active_o = m_act_q;
  assign m_last_o   = m_last_q;

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(valid_q)))
    else $error("occupied count disagrees with valid bits");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_ready_i))
    else $error("output register overwritten while stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("occupied count exceeds pool size");

endmodule
